@@ sv/scba_pkg.sv @@
// Shared types and constants for the size-class bitmap allocator.
`timescale 1ns / 1ps
package scba_pkg;

    localparam int BYTES_W   = 22;
    localparam int CLS_W     = 4;
    localparam int IDX_W     = 9;
    localparam int CNT_W     = 10;
    localparam int MAX_BYTES = 2097152;
    localparam int PAGE_SHIFT = 12;
    localparam int SMALL_CLASSES = 8;

    // Request kinds passed from front to back
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_DONE  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;

    typedef struct packed {
        logic [1:0]       op;
        logic [1:0]       stat;
        logic [CLS_W-1:0] cls;
        logic [IDX_W-1:0] chunk;
        logic [CNT_W-1:0] cnt;
    } t_req;

endpackage

@@ sv/size_class_bitmap_allocator_unit.sv @@
// Top level of the size-class bitmap allocator.
`timescale 1ns / 1ps
// Allocate or free requests are taken when start is high and busy is low; every
// request gives exactly one result, shown for one cycle with o_done, and the
// receiver cannot stall it. A two-entry queue sits between classification and
// the bitmap engine, so requests keep being taken while one is worked on. After
// reset, busy stays high while both chunk memories are cleared. The engine reads
// the class bitmap one chunk per cycle from a single memory port: an allocate
// scans the bitmap for a free run and then marks each granted chunk, a free
// reads the recorded run length and then clears each chunk of the run, and a
// rejected request is answered straight from idle.
module size_class_bitmap_allocator_unit #(
    parameter int CHUNKS_PER_CLASS = 512,
    parameter int NUM_CLASSES      = 9
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_action,
    input  logic [scba_pkg::BYTES_W-1:0] i_byte_count,
    input  logic [scba_pkg::CLS_W-1:0]   i_free_class,
    input  logic [scba_pkg::IDX_W-1:0]   i_free_chunk,
    output logic                         o_done,
    output logic [1:0]                   o_status,
    output logic [scba_pkg::CLS_W-1:0]   o_size_class,
    output logic [scba_pkg::IDX_W-1:0]   o_chunk_index,
    output logic [scba_pkg::CNT_W-1:0]   o_chunk_count
);
    import scba_pkg::*;

    t_req front_req, head_req;
    logic q_full, q_valid, q_pop, clearing, accept;

    assign busy   = q_full | clearing;
    assign accept = start & ~busy;

    scba_front #(
        .CHUNKS_PER_CLASS(CHUNKS_PER_CLASS),
        .NUM_CLASSES(NUM_CLASSES)
    ) u_front (
        .i_action(i_action),
        .i_byte_count(i_byte_count),
        .i_free_class(i_free_class),
        .i_free_chunk(i_free_chunk),
        .o_req(front_req)
    );

    scba_queue u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(accept),
        .i_data(front_req),
        .o_full(q_full),
        .i_pop(q_pop),
        .o_valid(q_valid),
        .o_data(head_req)
    );

    scba_back #(
        .CHUNKS_PER_CLASS(CHUNKS_PER_CLASS),
        .NUM_CLASSES(NUM_CLASSES)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req_valid(q_valid),
        .i_req(head_req),
        .o_pop(q_pop),
        .o_clearing(clearing),
        .o_done(o_done),
        .o_status(o_status),
        .o_size_class(o_size_class),
        .o_chunk_index(o_chunk_index),
        .o_chunk_count(o_chunk_count)
    );

endmodule

@@ sv/scba_front.sv @@
// Front end: classifies a request into size class and chunk count.
`timescale 1ns / 1ps
module scba_front #(
    parameter int CHUNKS_PER_CLASS = 512,
    parameter int NUM_CLASSES      = 9
) (
    input  logic                        i_action,
    input  logic [scba_pkg::BYTES_W-1:0] i_byte_count,
    input  logic [scba_pkg::CLS_W-1:0]   i_free_class,
    input  logic [scba_pkg::IDX_W-1:0]   i_free_chunk,
    output scba_pkg::t_req              o_req
);
    import scba_pkg::*;

    logic [CLS_W-1:0]   cls;
    logic [BYTES_W-1:0] rounded;
    logic [CNT_W-1:0]   need;

    always_comb begin
        cls = CLS_W'(SMALL_CLASSES);
        for (int c = SMALL_CLASSES - 1; c >= 0; c--) begin
            if (i_byte_count <= (BYTES_W'(2) << c)) begin
                cls = CLS_W'(c);
            end
        end
        rounded = i_byte_count + BYTES_W'((1 << PAGE_SHIFT) - 1);
        if (cls < CLS_W'(SMALL_CLASSES)) begin
            need = CNT_W'(1);
        end else begin
            need = CNT_W'(rounded >> PAGE_SHIFT);
        end
    end

    always_comb begin
        o_req.op    = OP_DONE;
        o_req.stat  = ST_BAD;
        o_req.cls   = '0;
        o_req.chunk = '0;
        o_req.cnt   = '0;
        if (i_action == ACT_ALLOC) begin
            if (i_byte_count == '0 || 32'(i_byte_count) > MAX_BYTES
                    || 32'(cls) >= NUM_CLASSES) begin
                o_req.op = OP_DONE;
            end else if (32'(need) > CHUNKS_PER_CLASS) begin
                o_req.stat = ST_NOSPACE;
                o_req.cls  = cls;
                o_req.cnt  = need;
            end else begin
                o_req.op   = OP_ALLOC;
                o_req.stat = ST_OK;
                o_req.cls  = cls;
                o_req.cnt  = need;
            end
        end else begin
            o_req.cls   = i_free_class;
            o_req.chunk = i_free_chunk;
            if (32'(i_free_class) < NUM_CLASSES && 32'(i_free_chunk) < CHUNKS_PER_CLASS) begin
                o_req.op   = OP_FREE;
                o_req.stat = ST_OK;
            end
        end
    end

endmodule

@@ sv/scba_queue.sv @@
// Two-entry request queue between front and back.
`timescale 1ns / 1ps
module scba_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scba_pkg::t_req i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output scba_pkg::t_req o_data
);
    import scba_pkg::*;

    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full)) else $error("request pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");

endmodule

@@ sv/scba_back.sv @@
// Back end: bitmap scan, run marking and freeing over the chunk memories.
`timescale 1ns / 1ps
module scba_back #(
    parameter int CHUNKS_PER_CLASS = 512,
    parameter int NUM_CLASSES      = 9
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  scba_pkg::t_req             i_req,
    output logic                       o_pop,
    output logic                       o_clearing,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [scba_pkg::CLS_W-1:0] o_size_class,
    output logic [scba_pkg::IDX_W-1:0] o_chunk_index,
    output logic [scba_pkg::CNT_W-1:0] o_chunk_count
);
    import scba_pkg::*;

    localparam int TOTAL = NUM_CLASSES * CHUNKS_PER_CLASS;
    localparam int CW    = $clog2(CHUNKS_PER_CLASS);
    localparam int NW    = CW + 1;
    localparam int AW    = $clog2(TOTAL);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_FISS  = 3'd4;
    localparam logic [2:0] S_FWAIT = 3'd5;
    localparam logic [2:0] S_FCLR  = 3'd6;

    logic          mem_used [TOTAL];
    logic [NW-1:0] mem_rl   [TOTAL];

    logic [2:0]       r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [AW-1:0]    r_base, n_base;
    logic [CLS_W-1:0] r_cls, n_cls;
    logic [CW-1:0]    r_chunk, n_chunk;
    logic [CW-1:0]    r_start, n_start;
    logic [CW-1:0]    r_pc, n_pc;
    logic [NW-1:0]    r_need, n_need;
    logic [NW-1:0]    r_run, n_run;
    logic [NW-1:0]    r_iss, n_iss;
    logic [NW-1:0]    r_k, n_k;
    logic             r_pend, n_pend;
    logic             r_valid, n_valid;
    logic [1:0]       r_stat, n_stat;
    logic [CLS_W-1:0] r_ocls, n_ocls;
    logic [IDX_W-1:0] r_oidx, n_oidx;
    logic [CNT_W-1:0] r_ocnt, n_ocnt;

    logic          r_used_q;
    logic [NW-1:0] r_rl_q;

    logic          used_we, used_wd, used_re;
    logic [AW-1:0] used_wa, used_ra;
    logic          rl_we, rl_re;
    logic [AW-1:0] rl_wa, rl_ra;
    logic [NW-1:0] rl_wd;
    logic [NW-1:0] run_nx, fcnt, flim;

    always_ff @(posedge i_clk) begin
        if (used_we) mem_used[used_wa] <= used_wd;
        if (used_re) r_used_q <= mem_used[used_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rl_we) mem_rl[rl_wa] <= rl_wd;
        if (rl_re) r_rl_q <= mem_rl[rl_ra];
    end

    always_comb begin
        n_state = r_state; n_clr = r_clr; n_base = r_base; n_cls = r_cls;
        n_chunk = r_chunk; n_start = r_start; n_pc = r_pc; n_need = r_need;
        n_run = r_run; n_iss = r_iss; n_k = r_k; n_pend = r_pend;
        n_valid = 1'b0; n_stat = r_stat; n_ocls = r_ocls; n_oidx = r_oidx;
        n_ocnt = r_ocnt;
        used_we = 1'b0; used_wd = 1'b0; used_re = 1'b0;
        used_wa = '0; used_ra = '0;
        rl_we = 1'b0; rl_re = 1'b0; rl_wa = '0; rl_ra = '0; rl_wd = '0;
        o_pop  = 1'b0;
        run_nx = r_run + NW'(1);
        fcnt   = (r_rl_q == '0) ? NW'(1) : r_rl_q;
        flim   = NW'(CHUNKS_PER_CLASS) - NW'(r_chunk);
        case (r_state)
            S_CLEAR: begin
                used_we = 1'b1;
                used_wa = r_clr;
                rl_we   = 1'b1;
                rl_wa   = r_clr;
                if (r_clr == AW'(TOTAL - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_pop   = 1'b1;
                    n_base  = AW'(32'(i_req.cls) * CHUNKS_PER_CLASS);
                    n_cls   = i_req.cls;
                    n_chunk = CW'(i_req.chunk);
                    n_need  = NW'(i_req.cnt);
                    n_iss   = '0;
                    n_run   = '0;
                    n_pend  = 1'b0;
                    case (i_req.op)
                        OP_ALLOC: n_state = S_SCAN;
                        OP_FREE:  n_state = S_FISS;
                        default: begin
                            n_valid = 1'b1;
                            n_stat  = i_req.stat;
                            n_ocls  = i_req.cls;
                            n_oidx  = i_req.chunk;
                            n_ocnt  = i_req.cnt;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Keep one read in flight; the bit for r_pc arrives now
                if (r_iss < NW'(CHUNKS_PER_CLASS)) begin
                    used_re = 1'b1;
                    used_ra = r_base + AW'(r_iss);
                    n_iss   = r_iss + NW'(1);
                    n_pc    = CW'(r_iss);
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (!r_used_q) begin
                        n_run = run_nx;
                        if (r_run == '0) n_start = r_pc;
                    end else begin
                        n_run = '0;
                    end
                    if (!r_used_q && run_nx == r_need) begin
                        n_state = S_MARK;
                        n_k     = '0;
                    end else if (r_pc == CW'(CHUNKS_PER_CLASS - 1)) begin
                        n_state = S_IDLE;
                        n_valid = 1'b1;
                        n_stat  = ST_NOSPACE;
                        n_ocls  = r_cls;
                        n_oidx  = '0;
                        n_ocnt  = CNT_W'(r_need);
                    end
                end
            end
            S_MARK: begin
                used_we = 1'b1;
                used_wd = 1'b1;
                used_wa = r_base + AW'(r_start) + AW'(r_k);
                if (r_k == '0) begin
                    rl_we = 1'b1;
                    rl_wa = r_base + AW'(r_start);
                    rl_wd = r_need;
                end
                if (r_k == r_need - NW'(1)) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_stat  = ST_OK;
                    n_ocls  = r_cls;
                    n_oidx  = IDX_W'(r_start);
                    n_ocnt  = CNT_W'(r_need);
                end else begin
                    n_k = r_k + NW'(1);
                end
            end
            S_FISS: begin
                rl_re   = 1'b1;
                rl_ra   = r_base + AW'(r_chunk);
                n_state = S_FWAIT;
            end
            S_FWAIT: begin
                // Clamp the recorded run at the end of the class
                n_need  = (fcnt > flim) ? flim : fcnt;
                rl_we   = 1'b1;
                rl_wa   = r_base + AW'(r_chunk);
                n_k     = '0;
                n_state = S_FCLR;
            end
            S_FCLR: begin
                used_we = 1'b1;
                used_wa = r_base + AW'(r_chunk) + AW'(r_k);
                if (r_k == r_need - NW'(1)) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_stat  = ST_OK;
                    n_ocls  = r_cls;
                    n_oidx  = IDX_W'(r_chunk);
                    n_ocnt  = CNT_W'(r_need);
                end else begin
                    n_k = r_k + NW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base; r_cls <= n_cls; r_chunk <= n_chunk; r_start <= n_start;
        r_pc <= n_pc; r_need <= n_need; r_run <= n_run; r_iss <= n_iss; r_k <= n_k;
        r_stat <= n_stat; r_ocls <= n_ocls; r_oidx <= n_oidx; r_ocnt <= n_ocnt;
    end

    assign o_clearing    = (r_state == S_CLEAR);
    assign o_done        = r_valid;
    assign o_status      = r_stat;
    assign o_size_class  = r_ocls;
    assign o_chunk_index = r_oidx;
    assign o_chunk_count = r_ocnt;

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE)) else $error("result strobe outside idle");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE)) else $error("request taken while busy");
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_run < r_need)) else $error("run overshot request");
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_valid) else $error("result during clearing");

endmodule
